[design/vm3d_pkg.sv]
// Shared widths and types for the three-axis vector magnitude block.
package vm3d_pkg;

    // Width of one signed axis sample.
    localparam int AXIS_W = 16;

    // One square of a 16-bit sample is at most 2^30, so it fits in 31 bits.
    localparam int SQ_W = 2 * AXIS_W - 1;

    // The sum of three squares is at most 3 * 2^30, so it fits in 32 bits.
    localparam int SUM_W = SQ_W + 1;

    // Root bits tried, from the top bit down. This also sets the output width.
    localparam int RESULT_BITS = 15;

    // Trial values are compared against the remainder with one spare bit.
    localparam int TRIAL_W = SUM_W + 1;

    typedef logic signed [AXIS_W-1:0]  t_axis;
    typedef logic [SQ_W-1:0]           t_square;
    typedef logic [SUM_W-1:0]          t_sum;
    typedef logic [RESULT_BITS-1:0]    t_root;
    typedef logic [TRIAL_W-1:0]        t_trial;

endpackage

[design/vector_magnitude_3d.sv]
// Three-axis vector magnitude: floor of the root of x*x + y*y + z*z.
//
// Input channel: i_valid, o_stall and the three signed 16-bit samples
// i_axis_x, i_axis_y, i_axis_z. A transfer happens at a rising edge with
// i_valid high and o_stall low.
// Output channel: o_valid, i_stall and the unsigned 15-bit o_vector_length.
// A transfer happens at a rising edge with o_valid high and i_stall low.
// The result saturates at 32767 when the true root is larger.
//
// Register stages, in order: one stage forms the three squares, one adds them,
// and fifteen stages each decide one root bit with a 33-bit compare and
// subtract. An item enters in every cycle unless o_stall is high, so throughput is one per cycle.
// Each transfer gives exactly one result, in order.
//
// Reset (synchronous, active low) empties the pipeline; no results are
// pending afterwards. When the receiver stalls, the output holds its value
// and the pipeline keeps filling its empty stages; o_stall rises only once
// every stage holds an item.
module vector_magnitude_3d
    import vm3d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_axis i_axis_x,
    input  t_axis i_axis_y,
    input  t_axis i_axis_z,
    output logic  o_valid,
    input  logic  i_stall,
    output t_root o_vector_length
);

    t_square n_sq_x;
    t_square n_sq_y;
    t_square n_sq_z;
    t_square r_sq_x;
    t_square r_sq_y;
    t_square r_sq_z;
    logic    r_sq_v;
    t_sum    n_sum;
    t_sum    r_sum;
    logic    r_sum_v;
    logic    root_ready;
    logic    en_sq;
    logic    en_sum;

    // Stage enables ripple back from the root pipeline.
    assign en_sum  = !r_sum_v || root_ready;
    assign en_sq   = !r_sq_v || en_sum;
    assign o_stall = !en_sq;

    // Squares of the samples; each is non-negative and at most 2^30.
    // The samples are sign-extended first, so the low bits of the product are exact.
    assign n_sq_x = SQ_W'(i_axis_x) * SQ_W'(i_axis_x);
    assign n_sq_y = SQ_W'(i_axis_y) * SQ_W'(i_axis_y);
    assign n_sq_z = SQ_W'(i_axis_z) * SQ_W'(i_axis_z);

    // Exact sum of squares; it never exceeds 3 * 2^30.
    assign n_sum = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    // Valid bits of the square and sum stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_sum_v <= 1'b0;
        end else begin
            if (en_sq) begin
                r_sq_v <= i_valid;
            end
            if (en_sum) begin
                r_sum_v <= r_sq_v;
            end
        end
    end

    // Square stage payload.
    always_ff @(posedge i_clk) begin
        if (en_sq) begin
            r_sq_x <= n_sq_x;
            r_sq_y <= n_sq_y;
            r_sq_z <= n_sq_z;
        end
    end

    // Sum stage payload.
    always_ff @(posedge i_clk) begin
        if (en_sum) begin
            r_sum <= n_sum;
        end
    end

    // Bit-by-bit root, one bit per stage; its last stage drives the output.
    vm3d_root_pipe u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_sum_v),
        .i_sum   (r_sum),
        .o_ready (root_ready),
        .o_valid (o_valid),
        .o_root  (o_vector_length),
        .i_stall (i_stall)
    );

endmodule

[design/vm3d_root_pipe.sv]
// Pipelined bit-by-bit integer square root, one result bit per register stage.
module vm3d_root_pipe
    import vm3d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_sum  i_sum,
    output logic  o_ready,
    output logic  o_valid,
    output t_root o_root,
    input  logic  i_stall
);

    // Per-stage state. Stage j decides root bit RESULT_BITS-1-j.
    t_root                  r_q   [RESULT_BITS];
    t_sum                   r_rem [RESULT_BITS-1];
    logic [RESULT_BITS-1:0] r_v;

    // Stage j may load when it is empty or when the stage after it loads.
    logic [RESULT_BITS:0]   en;

    assign en[RESULT_BITS] = !i_stall;
    assign o_ready         = en[0];
    assign o_valid         = r_v[RESULT_BITS-1];
    assign o_root          = r_q[RESULT_BITS-1];

    for (genvar j = 0; j < RESULT_BITS; j++) begin : g_stage
        localparam int K = RESULT_BITS - 1 - j;

        t_root  q_in;
        t_sum   rem_in;
        logic   v_in;
        t_trial trial;
        logic   take;
        t_root  n_q;

        // Ready ripples back from the output so bubbles are squeezed out.
        assign en[j] = !r_v[j] || en[j+1];

        // Stage inputs come from the port for the first stage.
        if (j == 0) begin : g_first
            assign q_in   = '0;
            assign rem_in = i_sum;
            assign v_in   = i_valid;
        end else begin : g_next
            assign q_in   = r_q[j-1];
            assign rem_in = r_rem[j-1];
            assign v_in   = r_v[j-1];
        end

        // (q + 2^K)^2 - q^2 = q * 2^(K+1) + 2^(2K); keep the bit if it still fits.
        assign trial = (TRIAL_W'(q_in) << (K + 1)) | (TRIAL_W'(1) << (2 * K));
        assign take  = {1'b0, rem_in} >= trial;
        assign n_q   = take ? (q_in | (RESULT_BITS'(1) << K)) : q_in;

        // Valid bit of the stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (en[j]) begin
                r_v[j] <= v_in;
            end
        end

        // Partial root of the stage.
        always_ff @(posedge i_clk) begin
            if (en[j]) begin
                r_q[j] <= n_q;
            end
        end

        // The remainder is needed by every stage but the last.
        if (j < RESULT_BITS - 1) begin : g_rem
            t_sum n_rem;

            assign n_rem = take ? (rem_in - trial[SUM_W-1:0]) : rem_in;

            always_ff @(posedge i_clk) begin
                if (en[j]) begin
                    r_rem[j] <= n_rem;
                end
            end
        end
    end

    // After reset the pipeline holds no items.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("root pipeline not empty after reset");

    // The pipeline only refuses an item when its first stage is occupied.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v[0])
        else $error("root pipeline refused an item with an empty first stage");

    for (genvar j = 0; j < RESULT_BITS; j++) begin : g_check
        localparam int K = RESULT_BITS - 1 - j;

        // A blocked stage keeps its item unchanged.
        a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_v[j] && !en[j]) |=> (r_v[j] && $stable(r_q[j])))
            else $error("blocked root stage lost or changed its item");

        // Bits below the one decided in a stage are still clear.
        a_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[j] |-> ((r_q[j] & ((RESULT_BITS'(1) << K) - RESULT_BITS'(1))) == '0))
            else $error("root stage set a bit that was not yet tried");
    end

endmodule
